// ===== src/date_ofs_pkg.sv =====
// ----------------------------------------------------------------------------
// date_ofs_pkg: shared types and tables for the date offset block
// state and status codes, 400/100/4/1-year cycle lengths, month lengths
// ----------------------------------------------------------------------------
package date_ofs_pkg;

  localparam int YearW   = 14;
  localparam int MonthW  = 4;
  localparam int DayW    = 5;
  localparam int OffsetW = 21;
  localparam int StatusW = 2;
  localparam int RemW    = 22;  // remainder / serial day number
  localparam int AccW    = 24;  // accumulator, signed once the offset is in
  localparam int QuoW    = 5;   // widest quotient of one cycle level
  localparam int ShiftW  = 3;

  localparam logic [YearW-1:0]  YearMax    = YearW'(9999);
  localparam logic [MonthW-1:0] MonthMax   = MonthW'(12);
  localparam logic [RemW-1:0]   LastSerial = RemW'(3652058);

  typedef enum logic [2:0] {
    StIdle,
    StFwd,   // year count -> serial day of 1 january
    StFmon,  // add lengths of the months before the start month
    StOff,   // add the signed offset, range check
    StBwd,   // serial day -> year and day of year
    StBmon,  // peel off months
    StDone
  } state_e;

  typedef enum logic [StatusW-1:0] {
    StatusOk      = 2'd0,
    StatusBadDate = 2'd1,
    StatusRange   = 2'd2
  } status_e;

  // years in one cycle level
  function automatic logic [RemW-1:0] year_unit(input logic [1:0] lvl);
    logic [RemW-1:0] u;
    unique case (lvl)
      2'd0: u = RemW'(400);
      2'd1: u = RemW'(100);
      2'd2: u = RemW'(4);
      2'd3: u = RemW'(1);
    endcase
    return u;
  endfunction

  // days in one cycle level
  function automatic logic [RemW-1:0] day_unit(input logic [1:0] lvl);
    logic [RemW-1:0] u;
    unique case (lvl)
      2'd0: u = RemW'(146097);
      2'd1: u = RemW'(36524);
      2'd2: u = RemW'(1461);
      2'd3: u = RemW'(365);
    endcase
    return u;
  endfunction

  // top quotient bit of a level: 5 bits for 400 and 4, 2 bits for 100 and 1
  function automatic logic [ShiftW-1:0] first_shift(input logic [1:0] lvl);
    return lvl[0] ? ShiftW'(1) : ShiftW'(4);
  endfunction

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] mon,
                                                input logic leap);
    logic [DayW-1:0] len;
    unique case (mon) inside
      4'd2:                   len = leap ? DayW'(29) : DayW'(28);
      4'd4, 4'd6, 4'd9, 4'd11: len = DayW'(30);
      default:                len = DayW'(31);
    endcase
    return len;
  endfunction

endpackage

// ===== src/date_offset_by_days.sv =====
// ----------------------------------------------------------------------------
// date_offset_by_days: gregorian date moved by a signed number of days
// iterative compare-subtract unit walks 400/100/4/1-year cycles and months
// ----------------------------------------------------------------------------
//
//  channel | handshake               | payload
//  --------+-------------------------+---------------------------------------
//  in      | in_valid_i / in_ready_o | start_year_i, start_month_i,
//          |                         | start_day_i, day_offset_i
//  out     | out_valid_o/out_ready_i | result_year_o, result_month_o,
//          |                         | result_day_o, status_o
//
//  one item at a time; a valid date passes from acceptance to out_valid_o
//  through the single compare-subtract unit, doing 14 quotient bits each
//  way plus one month a cycle; a malformed year or month goes from idle
//  straight to the result, a bad day is caught at the start month after
//  the forward pass; in_ready_o is high only while the sequencer is idle
//  a result waiting on out_ready_i holds in the output register while the
//  next item is already accepted and worked on
//  reset is asynchronous, active low, and clears the sequencer and out valid
//
module date_offset_by_days
  import date_ofs_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [YearW-1:0]          start_year_i,
  input  logic [MonthW-1:0]         start_month_i,
  input  logic [DayW-1:0]           start_day_i,
  input  logic signed [OffsetW-1:0] day_offset_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [YearW-1:0]          result_year_o,
  output logic [MonthW-1:0]         result_month_o,
  output logic [DayW-1:0]           result_day_o,
  output logic [StatusW-1:0]        status_o
);

  // sequencer
  state_e              state_q, state_d;
  logic [1:0]          lvl_q, lvl_d;      // cycle level: 400, 100, 4, 1 years
  logic [ShiftW-1:0]   shift_q, shift_d;  // quotient bit being tried
  logic [MonthW-1:0]   mon_q, mon_d;
  logic                out_valid_q, out_valid_d;

  // working registers
  logic [MonthW-1:0]         month_q, month_d;
  logic [DayW-1:0]           day_q, day_d;
  logic signed [OffsetW-1:0] offset_q, offset_d;
  logic [RemW-1:0]           a_q, a_d;    // remainder being divided
  logic [AccW-1:0]           b_q, b_d;    // accumulator of the other unit
  logic [QuoW-1:0]           quo_q, quo_d;
  logic                      hund3_q, hund3_d;  // 100-year quotient is 3
  logic                      c24_q, c24_d;      // 4-year quotient is 24
  logic                      leap_q, leap_d;
  status_e                   res_status_q, res_status_d;

  // output register
  logic [YearW-1:0]  res_year_q, res_year_d;
  logic [MonthW-1:0] res_month_q, res_month_d;
  logic [DayW-1:0]   res_day_q, res_day_d;
  status_e           out_status_q, out_status_d;

  // shared unit
  logic [RemW-1:0]  unit_year, unit_day, div_op;
  logic [AccW-1:0]  add_op, b_sum;
  logic [RemW-1:0]  a_diff;
  logic             a_ge;
  logic [DayW-1:0]  mlen;
  logic [QuoW-1:0]  quo_next;

  // decoded conditions
  logic bad_ym, step_last, last_mon, bad_day, out_of_range, more_months, out_free;

  // --------------------------------------------------------------------------
  // shared compare-subtract on the remainder and add on the accumulator
  // --------------------------------------------------------------------------
  // forward: remainder counts years, accumulator collects days
  // backward: remainder counts days, accumulator collects years
  assign unit_year = year_unit(lvl_q) << shift_q;
  assign unit_day  = day_unit(lvl_q) << shift_q;
  assign mlen      = month_len(mon_q, leap_q);
  assign last_mon  = (mon_q == month_q);

  always_comb begin
    case (state_q)
      StFwd:   div_op = unit_year;
      StBwd:   div_op = unit_day;
      StBmon:  div_op = RemW'(mlen);
      default: div_op = '0;
    endcase
  end

  always_comb begin
    case (state_q)
      StFwd:   add_op = AccW'(unit_day);
      StBwd:   add_op = AccW'(unit_year);
      // at the start month, add the day of month less one
      StFmon:  add_op = last_mon ? AccW'(day_q - DayW'(1)) : AccW'(mlen);
      StOff:   add_op = {{(AccW-OffsetW){offset_q[OffsetW-1]}}, offset_q};
      default: add_op = '0;
    endcase
  end

  assign a_ge     = (a_q >= div_op);
  assign a_diff   = a_q - div_op;
  assign b_sum    = b_q + add_op;
  assign quo_next = {quo_q[QuoW-2:0], a_ge};

  // --------------------------------------------------------------------------
  // decoded conditions
  // --------------------------------------------------------------------------
  assign bad_ym = (start_year_i == '0) || (start_year_i > YearMax) ||
                  (start_month_i == '0) || (start_month_i > MonthMax);
  assign step_last    = (lvl_q == 2'd3) && (shift_q == '0);
  assign bad_day      = (day_q == '0) || (day_q > mlen);
  // serial day number must land in 0 .. 9999-12-31
  assign out_of_range = b_sum[AccW-1] || b_sum[AccW-2] || (b_sum[RemW-1:0] > LastSerial);
  assign more_months  = a_ge && (mon_q < MonthMax);
  assign out_free     = !out_valid_q || out_ready_i;

  // --------------------------------------------------------------------------
  // next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = bad_ym ? StDone : StFwd;
        end
      end
      StFwd: begin
        if (step_last) begin
          state_d = StFmon;
        end
      end
      StFmon: begin
        if (last_mon) begin
          state_d = bad_day ? StDone : StOff;
        end
      end
      StOff: begin
        state_d = out_of_range ? StDone : StBwd;
      end
      StBwd: begin
        if (step_last) begin
          state_d = StBmon;
        end
      end
      StBmon: begin
        if (!more_months) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // --------------------------------------------------------------------------
  // datapath and outputs
  // --------------------------------------------------------------------------
  always_comb begin
    lvl_d        = lvl_q;
    shift_d      = shift_q;
    mon_d        = mon_q;
    month_d      = month_q;
    day_d        = day_q;
    offset_d     = offset_q;
    a_d          = a_q;
    b_d          = b_q;
    quo_d        = quo_q;
    hund3_d      = hund3_q;
    c24_d        = c24_q;
    leap_d       = leap_q;
    res_status_d = res_status_q;
    res_year_d   = res_year_q;
    res_month_d  = res_month_q;
    res_day_d    = res_day_q;
    out_status_d = out_status_q;
    out_valid_d  = out_valid_q && !out_ready_i;

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          month_d      = start_month_i;
          day_d        = start_day_i;
          offset_d     = day_offset_i;
          a_d          = RemW'(start_year_i - YearW'(1));  // completed years
          b_d          = '0;
          lvl_d        = 2'd0;
          shift_d      = first_shift(2'd0);
          quo_d        = '0;
          res_status_d = bad_ym ? StatusBadDate : StatusOk;
        end
      end
      StFwd, StBwd: begin
        // one restoring division bit of the current level
        quo_d = quo_next;
        if (a_ge) begin
          a_d = a_diff;
          b_d = b_sum;
        end
        if (shift_q == '0) begin
          case (lvl_q)
            2'd1:    hund3_d = (quo_next[1:0] == 2'b11);
            2'd2:    c24_d   = (quo_next == QuoW'(24));
            // year index 3 of a 4-year run is leap unless a century not of 400
            2'd3:    leap_d  = (quo_next[1:0] == 2'b11) && (!c24_q || hund3_q);
            default: ;
          endcase
          if (lvl_q == 2'd3) begin
            mon_d = MonthW'(1);
          end else begin
            lvl_d   = lvl_q + 2'd1;
            shift_d = first_shift(lvl_q + 2'd1);
            quo_d   = '0;
          end
        end else begin
          shift_d = shift_q - ShiftW'(1);
        end
      end
      StFmon: begin
        b_d = b_sum;
        if (last_mon) begin
          if (bad_day) begin
            res_status_d = StatusBadDate;
          end
        end else begin
          mon_d = mon_q + MonthW'(1);
        end
      end
      StOff: begin
        a_d     = b_sum[RemW-1:0];
        b_d     = AccW'(1);  // years start at 1
        lvl_d   = 2'd0;
        shift_d = first_shift(2'd0);
        quo_d   = '0;
        if (out_of_range) begin
          res_status_d = StatusRange;
        end
      end
      StBmon: begin
        if (more_months) begin
          a_d   = a_diff;
          mon_d = mon_q + MonthW'(1);
        end
      end
      StDone: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          if (res_status_q == StatusOk) begin
            res_year_d  = b_q[YearW-1:0];
            res_month_d = mon_q;
            res_day_d   = a_q[DayW-1:0] + DayW'(1);
          end else begin
            res_year_d  = '0;
            res_month_d = '0;
            res_day_d   = '0;
          end
        end
      end
      default: ;
    endcase
  end

  assign in_ready_o     = (state_q == StIdle);
  assign out_valid_o    = out_valid_q;
  assign result_year_o  = res_year_q;
  assign result_month_o = res_month_q;
  assign result_day_o   = res_day_q;
  assign status_o       = out_status_q;

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      lvl_q       <= '0;
      shift_q     <= '0;
      mon_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lvl_q       <= lvl_d;
      shift_q     <= shift_d;
      mon_q       <= mon_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    month_q      <= month_d;
    day_q        <= day_d;
    offset_q     <= offset_d;
    a_q          <= a_d;
    b_q          <= b_d;
    quo_q        <= quo_d;
    hund3_q      <= hund3_d;
    c24_q        <= c24_d;
    leap_q       <= leap_d;
    res_status_q <= res_status_d;
    res_year_q   <= res_year_d;
    res_month_q  <= res_month_d;
    res_day_q    <= res_day_d;
    out_status_q <= out_status_d;
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // an accepted item always starts the sequencer
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q != StIdle)
    else $error("accepted item did not leave idle");

  // the day-of-year remainder fits in one year before the month walk
  a_bmon_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StBmon |-> a_q <= RemW'(365))
    else $error("day-of-year remainder too large");

  // a good result is a well-formed date
  a_ok_date: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == StatusOk |->
      result_year_o != '0 && result_year_o <= YearMax &&
      result_month_o != '0 && result_month_o <= MonthMax && result_day_o != '0)
    else $error("ok result is not a valid date");

  // a flagged result carries zero fields
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != StatusOk |->
      result_year_o == '0 && result_month_o == '0 && result_day_o == '0)
    else $error("flagged result has non-zero fields");

endmodule
